// ===== hdl/gwm_pkg.sv =====
// Shared types and constants for the glob wildcard matcher.
// Used by gwm_cell, gwm_out_buf and glob_wildcard_matcher_unit; no dependencies.
package gwm_pkg;

	// Item kinds carried in the input tuser field
	typedef enum logic [1:0] {
		OP_PATTERN = 2'd0,
		OP_NAME    = 2'd1,
		OP_END     = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	// Wildcard symbols in the pattern
	localparam logic [7:0] SYM_STAR = 8'h2A;
	localparam logic [7:0] SYM_ANY  = 8'h3F;
	localparam logic [7:0] SYM_NUL  = 8'h00;

	// Per-cycle control broadcast to every cell of the row
	typedef struct packed {
		logic       step;    // name byte: advance active positions
		logic       restart; // pattern symbol or verdict: reload start closure
		logic [7:0] sym;     // pattern symbol or name byte
	} ctrl_t;

	// One verdict
	typedef struct packed {
		logic pattern_overflow;
		logic matched;
	} res_t;

endpackage

// ===== hdl/glob_wildcard_matcher_unit.sv =====
// Glob matcher ('*' any run, '?' one byte): a row of MAX_PATTERN position cells.
// Accepts one item per cycle while the skid stage is free; each verdict is
// registered from its end-of-name item. The row updates every active bit per
// name byte. The skid stage lets input flow on while a verdict waits to be taken.
// Reset: empty pattern, no overflow, start position active; stored bytes unreset.
module glob_wildcard_matcher_unit import gwm_pkg::*; #(
	parameter int MAX_PATTERN = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,  // [7:0] symbol
	input  logic [7:0] s_tuser,  // [1:0] op, [2] first, [7:3] zero
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata   // [0] matched, [1] pattern_overflow, [7:2] zero
);

	localparam int LW = $clog2(MAX_PATTERN + 1);

	op_t           op;
	logic          accept;
	logic          load;
	logic          verdict;
	ctrl_t         ctrl;
	logic [LW-1:0] len_q;
	logic          ovf_q;
	logic          act_end_q;
	logic [LW-1:0] base_len;
	logic          sym_nz;
	logic          full;
	logic          wr_en;
	logic [LW-1:0] len_use;
	logic          ovf_d;
	logic [MAX_PATTERN:0]   adv;
	logic [MAX_PATTERN:0]   close;
	logic [MAX_PATTERN-1:0] end_hits;
	logic          end_last;
	res_t          res;
	res_t          m_res;

	// Decode the accepted item
	always_comb begin
		op           = op_t'(s_tuser[1:0]);
		accept       = s_tvalid && s_tready;
		load         = accept && (op == OP_PATTERN);
		verdict      = accept && (op == OP_END);
		ctrl.step    = accept && (op == OP_NAME);
		ctrl.restart = load || verdict;
		ctrl.sym     = s_tdata;
	end

	// Pattern length and overflow bookkeeping
	always_comb begin
		base_len = s_tuser[2] ? '0 : len_q;
		sym_nz   = s_tdata != SYM_NUL;
		full     = base_len == LW'(MAX_PATTERN);
		wr_en    = load && sym_nz && !full;
		if (load) begin
			len_use = wr_en ? LW'(base_len + 1'b1) : base_len;
		end else begin
			len_use = len_q;
		end
		ovf_d = (!s_tuser[2] && ovf_q) || (sym_nz && full);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			ovf_q <= 1'b0;
		end else if (load) begin
			len_q <= len_use;
			ovf_q <= ovf_d;
		end
	end

	// Row of position cells
	assign adv[0]   = 1'b0;
	assign close[0] = 1'b0;

	for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
		gwm_cell #(
			.LW  (LW),
			.IDX (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.wr_en     (wr_en),
			.wr_addr   (base_len),
			.len       (len_use),
			.adv_in    (adv[i]),
			.close_in  (close[i]),
			.adv_out   (adv[i+1]),
			.close_out (close[i+1]),
			.end_hit   (end_hits[i])
		);
	end

	// Active bit for the position past the last cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_end_q <= 1'b0;
		end else if (ctrl.step || ctrl.restart) begin
			act_end_q <= adv[MAX_PATTERN] || close[MAX_PATTERN];
		end
	end

	// Verdict
	always_comb begin
		end_last             = act_end_q && (len_q == LW'(MAX_PATTERN));
		res.matched          = !ovf_q && ((|end_hits) || end_last);
		res.pattern_overflow = ovf_q;
	end

	gwm_out_buf u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (verdict),
		.push_res (res),
		.ready    (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_res    (m_res)
	);

	assign m_tdata = {6'd0, m_res.pattern_overflow, m_res.matched};

endmodule

// ===== hdl/gwm_cell.sv =====
// One pattern position: stores its pattern byte and its active bit.
// Depends on gwm_pkg; hands advance and star-closure bits to the next cell.
module gwm_cell import gwm_pkg::*; #(
	parameter int LW  = 6,
	parameter int IDX = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  ctrl_t         ctrl,
	input  logic          wr_en,
	input  logic [LW-1:0] wr_addr,
	input  logic [LW-1:0] len,
	input  logic          adv_in,
	input  logic          close_in,
	output logic          adv_out,
	output logic          close_out,
	output logic          end_hit
);

	logic [7:0] sym_q;
	logic       act_q;
	logic [7:0] byte_new;
	logic       in_pat;
	logic       is_star;
	logic       pre;
	logic       act_d;

	// Resolve this position's byte, including a write in this cycle
	always_comb begin
		byte_new = (wr_en && (wr_addr == LW'(IDX))) ? ctrl.sym : sym_q;
		in_pat   = LW'(IDX) < len;
		is_star  = in_pat && (byte_new == SYM_STAR);
	end

	// Advance on a name byte, restart, then close over stars
	always_comb begin
		adv_out = ctrl.step && act_q && in_pat && !is_star &&
			((byte_new == SYM_ANY) || (byte_new == ctrl.sym));
		if (ctrl.restart) begin
			pre = (IDX == 0);
		end else begin
			pre = (act_q && is_star) || adv_in;
		end
		act_d     = pre || close_in;
		close_out = act_d && is_star;
		end_hit   = act_q && (len == LW'(IDX));
	end

	// Hold pattern byte
	always_ff @(posedge clk) begin
		if (wr_en && (wr_addr == LW'(IDX))) begin
			sym_q <= ctrl.sym;
		end
	end

	// Update active bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= (IDX == 0);
		end else if (ctrl.step || ctrl.restart) begin
			act_q <= act_d;
		end
	end

endmodule

// ===== hdl/gwm_out_buf.sv =====
// Verdict output register with a one-entry skid stage.
// Depends on gwm_pkg for the result type.
module gwm_out_buf import gwm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  res_t push_res,
	output logic ready,
	output logic m_tvalid,
	input  logic m_tready,
	output res_t m_res
);

	logic out_valid_q;
	res_t out_res_q;
	logic skid_valid_q;
	res_t skid_res_q;
	logic out_free;

	assign out_free = !out_valid_q || m_tready;
	assign ready    = !skid_valid_q;
	assign m_tvalid = out_valid_q;
	assign m_res    = out_res_q;

	// Move skid or new item into the output register when it frees up
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q  <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (out_free) begin
			out_res_q <= skid_valid_q ? skid_res_q : push_res;
		end else if (push) begin
			skid_res_q <= push_res;
		end
	end

endmodule

// ===== verif/glob_wildcard_matcher_unit_test.sv =====
// Self-checking bench for glob_wildcard_matcher_unit: streams patterns and names,
// predicts each verdict and compares it at the output. Depends on gwm_pkg and the unit.
`timescale 1ns / 1ps

module glob_wildcard_matcher_unit_test;
	import gwm_pkg::*;

	localparam int PAT_DEPTH = 32;
	localparam int N_ITEMS   = 1800;
	localparam int LIMIT     = 400000;

	logic       clk      = 1'b0;
	logic       arst_n   = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata  = 8'h00; // [7:0] symbol
	logic [7:0] s_tuser  = 8'h00; // [1:0] op, [2] first, [7:3] zero
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;          // [0] matched, [1] pattern_overflow, [7:2] zero

	// Predict verdicts from accepted items and hold them until they come out
	class match_board;
		logic [7:0]         pat [PAT_DEPTH];
		int unsigned        plen;
		logic [PAT_DEPTH:0] live;
		bit                 ovf;
		res_t               due_q [$];
		int unsigned        errors;
		int unsigned        verdicts;
		int unsigned        hits;
		int unsigned        ovf_verdicts;

		function new();
			plen = 0;
			ovf  = 0;
			live = restart_row();
		endfunction

		// Carry activity across stars, which may match nothing
		function logic [PAT_DEPTH:0] star_closure(logic [PAT_DEPTH:0] a);
			for (int i = 0; i < plen; i++)
				if (a[i] && pat[i] == SYM_STAR) a[i+1] = 1'b1;
			return a;
		endfunction

		function logic [PAT_DEPTH:0] restart_row();
			return star_closure({{PAT_DEPTH{1'b0}}, 1'b1});
		endfunction

		function int unsigned pending();
			return due_q.size();
		endfunction

		function void flag(string what, logic [7:0] want, logic [7:0] got);
			errors++;
			if (errors <= 10)
				$display("%0t: %s mismatch, expected %h got %h", $time, what, want, got);
		endfunction

		function void note_item(op_t op, logic [7:0] sym, logic fst);
			logic [PAT_DEPTH:0] nxt;
			res_t               want;
			case (op)
				OP_PATTERN: begin
					if (fst) begin
						plen = 0;
						ovf  = 0;
					end
					// a zero symbol is not stored and leaves the pattern as it is
					if (sym != SYM_NUL) begin
						if (plen < PAT_DEPTH) begin
							pat[plen] = sym;
							plen++;
						end else begin
							ovf = 1;
						end
					end
					live = restart_row();
				end
				OP_NAME: begin
					nxt = '0;
					for (int i = 0; i < plen; i++) begin
						if (live[i]) begin
							if (pat[i] == SYM_STAR) nxt[i] = 1'b1;
							else if (pat[i] == SYM_ANY || pat[i] == sym) nxt[i+1] = 1'b1;
						end
					end
					live = star_closure(nxt);
				end
				OP_END: begin
					want.matched          = !ovf && live[plen];
					want.pattern_overflow = ovf;
					due_q.push_back(want);
					live = restart_row();
				end
				default: ;
			endcase
		endfunction

		function void check_verdict(logic [7:0] got);
			res_t want;
			if (due_q.size() == 0) begin
				flag("unexpected verdict", 8'hxx, got);
				return;
			end
			want = due_q.pop_front();
			verdicts++;
			hits         += want.matched;
			ovf_verdicts += want.pattern_overflow;
			if (got[0] !== want.matched) flag("matched", 8'(want.matched), 8'(got[0]));
			if (got[1] !== want.pattern_overflow)
				flag("pattern_overflow", 8'(want.pattern_overflow), 8'(got[1]));
			if (got[7:2] !== 6'd0) flag("pad bits", 8'h00, 8'(got[7:2]));
		endfunction
	endclass

	match_board  sb = new();
	int          items_sent = 0;
	int          burst_left = 0;
	int          cycles     = 0;
	logic [7:0]  gp [$];
	bit          gen_ovf    = 0;
	int          hold_req   = 0;
	int          hold_ack   = 0;
	int          hold_left  = 0;
	int          rx_mode    = 0;
	int          rx_left    = 0;

	glob_wildcard_matcher_unit #(.MAX_PATTERN(PAT_DEPTH)) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Note every accepted input item
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			sb.note_item(op_t'(s_tuser[1:0]), s_tdata, s_tuser[2]);
	end

	// Check every accepted verdict
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_verdict(m_tdata);
	end

	// Drive the output ready: long hold on request, else phases of varying stall
	always @(posedge clk) begin
		if (hold_req != hold_ack) begin
			hold_ack  = hold_req;
			hold_left = $urandom_range(180, 260);
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			if (rx_left == 0) begin
				rx_mode = $urandom_range(0, 2);
				rx_left = $urandom_range(20, 120);
			end
			rx_left--;
			case (rx_mode)
				0:       m_tready <= 1'b1;
				1:       m_tready <= 1'($urandom_range(0, 1));
				default: m_tready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// Stop a hung run
	initial begin
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("glob_wildcard_matcher_unit test failed");
		$finish;
	end

	function automatic logic [7:0] name_byte();
		logic [7:0] alpha [4] = '{8'h61, 8'h62, 8'h63, 8'h2E};
		if ($urandom_range(0, 9) < 7) return alpha[$urandom_range(0, 3)];
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] pat_sym();
		int r;
		r = $urandom_range(0, 9);
		if (r < 2) return SYM_STAR;
		if (r == 2) return SYM_ANY;
		if (r < 9) return name_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic int pick_len();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0) return 0;
		if (r == 1) return PAT_DEPTH + $urandom_range(0, 3);
		if (r < 4) return $urandom_range(9, PAT_DEPTH);
		return $urandom_range(1, 8);
	endfunction

	// Offer one item in bursts with random gaps; return once it is taken
	task automatic offer(input op_t op, input logic [7:0] sym, input logic fst);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= sym;
		s_tuser  <= {5'b00000, fst, op};
		do @(posedge clk); while (!s_tready);
		// track the loaded pattern so names can be shaped to it
		if (op == OP_PATTERN) begin
			if (fst) begin
				gp.delete();
				gen_ovf = 0;
			end
			if (sym != SYM_NUL) begin
				if (gp.size() < PAT_DEPTH) gp.push_back(sym);
				else gen_ovf = 1;
			end
		end
		if (op != OP_NONE) items_sent++;
	endtask

	task automatic load_pattern(input int n);
		if (n == 0) offer(OP_PATTERN, SYM_NUL, 1'b1);
		for (int i = 0; i < n; i++) offer(OP_PATTERN, pat_sym(), i == 0);
	endtask

	// Send one name and its end item; shaped names follow the pattern, then may mutate
	task automatic send_name(input bit shaped);
		logic [7:0] nm [$];
		if (shaped && !gen_ovf) begin
			foreach (gp[i]) begin
				if (gp[i] == SYM_STAR) repeat ($urandom_range(0, 3)) nm.push_back(name_byte());
				else if (gp[i] == SYM_ANY) nm.push_back(8'($urandom_range(0, 255)));
				else nm.push_back(gp[i]);
			end
			if ($urandom_range(0, 2) == 0) begin
				case ($urandom_range(0, 2))
					0: if (nm.size() > 0) nm[$urandom_range(0, nm.size() - 1)] = name_byte();
					1: if (nm.size() > 0) void'(nm.pop_back());
					default: nm.push_back(name_byte());
				endcase
			end
		end else begin
			repeat ($urandom_range(0, 10)) nm.push_back(name_byte());
		end
		foreach (nm[i]) offer(OP_NAME, nm[i], $urandom_range(0, 7) == 0);
		offer(OP_END, 8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
	endtask

	// Hold the input until every expected verdict has come out
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	initial begin
		bit held;
		bit paused;
		held   = 0;
		paused = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty pattern against empty name, then against a zero byte
		offer(OP_END, 8'h00, 1'b0);
		offer(OP_NAME, 8'h00, 1'b0);
		offer(OP_END, 8'hFF, 1'b0);
		// lone star: empty name, then a zero byte and an all-ones byte
		offer(OP_PATTERN, SYM_STAR, 1'b1);
		offer(OP_END, 8'h00, 1'b0);
		offer(OP_NAME, 8'h00, 1'b0);
		offer(OP_NAME, 8'hFF, 1'b0);
		offer(OP_END, 8'h00, 1'b0);
		// zero pattern symbol is not stored; question mark takes a zero byte
		offer(OP_PATTERN, SYM_ANY, 1'b1);
		offer(OP_PATTERN, SYM_NUL, 1'b0);
		offer(OP_NAME, 8'h00, 1'b0);
		offer(OP_END, 8'h00, 1'b0);
		// clear with a zero symbol leaves the pattern empty
		offer(OP_PATTERN, SYM_NUL, 1'b1);
		offer(OP_END, 8'h00, 1'b0);
		// pattern change in the middle of a name drops the name
		offer(OP_PATTERN, 8'h61, 1'b1);
		offer(OP_NAME, 8'h61, 1'b0);
		offer(OP_PATTERN, SYM_STAR, 1'b0);
		offer(OP_NAME, 8'h80, 1'b0);
		offer(OP_END, 8'h00, 1'b0);
		// unused op is ignored; first flag on name and end items has no effect
		offer(OP_NONE, 8'hFF, 1'b1);
		offer(OP_NAME, 8'h61, 1'b0);
		offer(OP_END, 8'h00, 1'b0);
		offer(OP_NAME, 8'h61, 1'b1);
		offer(OP_END, 8'hFF, 1'b1);

		// exactly full store, then store overflow
		load_pattern(PAT_DEPTH);
		send_name(1);
		load_pattern(PAT_DEPTH + 2);
		send_name(1);
		send_name(0);

		// random patterns and names, with some noise
		while (items_sent < N_ITEMS) begin
			if (!held && items_sent > N_ITEMS / 3) begin
				// stall the output long while end items keep coming
				held = 1;
				hold_req++;
				burst_left = 48;
				repeat (40) offer(OP_END, 8'($urandom_range(0, 255)), 1'b0);
			end
			if (!paused && items_sent > 2 * N_ITEMS / 3) begin
				paused = 1;
				drain();
			end
			case ($urandom_range(0, 9))
				0, 1: load_pattern(pick_len());
				2: repeat ($urandom_range(1, 4))
					offer(op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
						1'($urandom_range(0, 1)));
				3: send_name(0);
				default: send_name(1);
			endcase
		end

		drain();
		repeat (8) @(posedge clk);
		sb.errors += sb.pending();
		$display("Checked %0d verdicts (%0d matches, %0d on an overflowed pattern)",
			sb.verdicts, sb.hits, sb.ovf_verdicts);
		$display("from %0d items over patterns up to past store depth %0d, %0d errors",
			items_sent, PAT_DEPTH, sb.errors);
		if (sb.errors == 0) begin
			$display("glob_wildcard_matcher_unit test passed");
		end else begin
			$display("glob_wildcard_matcher_unit test failed");
		end
		$finish;
	end

endmodule
